// ===== rtl/core/pht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pht_pkg: shared types and constants of the probed hash table cache
// field widths, action codes, table entry layout and sequencer states
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int DEPTH_W  = 6;
  localparam int VALUE_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [DEPTH_W-1:0]  search_depth;
    logic [VALUE_W-1:0]  value_word;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] found_value;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_CLEAR,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pht_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pht_in_if: request channel of the probed hash table cache
// valid/ready handshake carrying one action with its key, depth and value
// ----------------------------------------------------------------------------
interface pht_in_if import pht_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [DEPTH_W-1:0]  search_depth;
  logic [VALUE_W-1:0]  value_word;

  modport source (
    output valid, action, key, search_depth, value_word,
    input  ready
  );

  modport sink (
    input  valid, action, key, search_depth, value_word,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/pht_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pht_out_if: result channel of the probed hash table cache
// valid/ready handshake carrying the hit flag and the found value
// ----------------------------------------------------------------------------
interface pht_out_if import pht_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] found_value;

  modport source (
    output valid, hit, found_value,
    input  ready
  );

  modport sink (
    input  valid, hit, found_value,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/probed_hash_table_cache_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// probed_hash_table_cache_core: hash table cache with bounded linear probing
// lookup, store and clear of keyed entries in a two-port (write/read) slot memory
// ----------------------------------------------------------------------------
// Usage: ENTRIES must be a power of two; the home slot of a key is its low
// log2(ENTRIES) bits and the probe window of PROBES slots wraps at the end
// of the table. Each request transaction yields exactly one result
// transaction (hit and found_value are zero for store, clear and the unused
// action code). A lookup or store is accepted from idle and then walks its
// probe window slot by slot, every probe being one read of the single slot
// memory through one key/depth comparator; the deciding probe waits while the
// result register is still full. A clear sweeps the valid marks one slot per
// cycle. After reset the same sweep runs before the first request is taken.
// A finished result sits in an output register, so the next request is
// taken while the previous result still waits for its consumer.
// ----------------------------------------------------------------------------
module probed_hash_table_cache_core import pht_pkg::*; #(
  parameter int ENTRIES = 4096,
  parameter int PROBES  = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  pht_in_if.sink    in_chan,
  pht_out_if.source out_chan
);

  localparam int IDX_W = $clog2(ENTRIES);

  // request payload gathered into one item
  item_t            in_item;
  res_t             res;
  logic             res_load;
  logic             out_free;

  // slot memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // result register
  logic             out_valid_r;
  res_t             res_r;

  assign in_item.action       = in_chan.action;
  assign in_item.key          = in_chan.key;
  assign in_item.search_depth = in_chan.search_depth;
  assign in_item.value_word   = in_chan.value_word;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  pht_seq #(
    .ENTRIES (ENTRIES),
    .PROBES  (PROBES),
    .IDX_W   (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pht_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output stage: load on a finished request, drop when the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = res_r.hit;
  assign out_chan.found_value = res_r.found_value;

`ifndef SYNTHESIS
  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result register overwritten while pending");

  // a request is never taken in the cycle its predecessor finishes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !in_chan.ready)
    else $error("request taken while another completes");

  // result valid only rises right after a result load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_load))
    else $error("result valid without a load");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pht_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pht_mem: slot storage of the probed hash table cache
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pht_mem import pht_pkg::*; #(
  parameter int ENTRIES = 4096,
  parameter int IDX_W   = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/pht_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pht_seq: probe sequencer of the probed hash table cache
// walks the probe window one slot a cycle via a single key/depth comparator,
// stalls while the result is blocked; sweeps valid marks on reset and clear
// ----------------------------------------------------------------------------
module pht_seq import pht_pkg::*; #(
  parameter int ENTRIES = 4096,
  parameter int PROBES  = 4,
  parameter int IDX_W   = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic             out_free,
  output logic             res_load,
  output res_t             res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata
);

  localparam int PRB_W = (PROBES > 1) ? $clog2(PROBES) : 1;

  state_t            state_r, state_nxt;
  item_t             item_r;
  logic [PRB_W-1:0]  probe_r;
  logic [IDX_W-1:0]  sweep_r;

  logic              accept;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  slot_cur;
  logic              last_probe;
  logic              last_sweep;
  logic              key_eq;
  logic              depth_ok;
  logic              is_store;
  logic              take;
  logic              decide;

  assign accept     = in_valid && in_ready;
  assign home       = item_r.key[IDX_W-1:0];
  assign slot_cur   = home + IDX_W'(probe_r);
  assign last_probe = (probe_r == PRB_W'(PROBES - 1));
  assign last_sweep = (sweep_r == IDX_W'(ENTRIES - 1));

  // shared comparator on the slot just read
  assign key_eq   = (mem_rdata.key == item_r.key);
  assign depth_ok = (mem_rdata.depth >= item_r.search_depth);
  assign is_store = (item_r.action == ACT_STORE);
  assign take     = !mem_rdata.valid || key_eq;

  always_comb begin
    if (is_store) begin
      decide = take || last_probe;
    end else begin
      decide = !mem_rdata.valid || (key_eq && depth_ok) || last_probe;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (last_sweep) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_LOOKUP: state_nxt = ST_PROBE;
            ACT_STORE:  state_nxt = ST_PROBE;
            ACT_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PROBE: begin
        if (decide && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (last_sweep) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    res_load        = 1'b0;
    res.hit         = 1'b0;
    res.found_value = '0;
    mem_we          = 1'b0;
    mem_waddr       = sweep_r;
    mem_wdata       = '0;
    mem_raddr       = slot_cur;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = in_item.key[IDX_W-1:0];
      end
      ST_PROBE: begin
        // read ahead to the next slot unless this one ends the walk
        if (!decide) begin
          mem_raddr = slot_cur + IDX_W'(1);
        end
        if (decide && out_free) begin
          res_load = 1'b1;
          if (is_store) begin
            mem_we          = 1'b1;
            mem_waddr       = take ? slot_cur : home;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = item_r.key;
            mem_wdata.value = item_r.value_word;
            mem_wdata.depth = item_r.search_depth;
          end else if (mem_rdata.valid && key_eq && depth_ok) begin
            res.hit         = 1'b1;
            res.found_value = mem_rdata.value;
          end
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RESP: begin
        res_load = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sweep_r <= '0;
      probe_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT || state_r == ST_CLEAR) begin
        sweep_r <= sweep_r + IDX_W'(1);
      end else begin
        sweep_r <= '0;
      end
      if (accept) begin
        probe_r <= '0;
      end else if (state_r == ST_PROBE && !decide) begin
        probe_r <= probe_r + PRB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire
